### design/lpir_pkg.sv
// shared constants, types and codes for the log position index ring
package lpir_pkg;

    localparam int DEPTH   = 1024;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = 64;
    localparam int LOC_W   = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP       = 3'd1;
    localparam logic [OP_W-1:0] OP_TRUNC_AFTER  = 3'd2;
    localparam logic [OP_W-1:0] OP_TRUNC_BEFORE = 3'd3;
    localparam logic [OP_W-1:0] OP_MIN_SEG      = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NONSEQ   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_CMP,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic cmp;
        logic exec;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [LOC_W-1:0] seg;
        logic [LOC_W-1:0] blk;
        logic [LOC_W-1:0] ent;
    } loc_t;

endpackage

### design/lpir_ctrl.sv
// controller state machine sequencing one item through the datapath
module lpir_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output lpir_pkg::ctrl_cmd_t cmd
);
    import lpir_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### design/lpir_dp.sv
// datapath: ring pointers, index arithmetic and location memory
module lpir_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lpir_pkg::ctrl_cmd_t                 cmd,
    input  logic [lpir_pkg::OP_W-1:0]           operation,
    input  logic [lpir_pkg::IDX_W-1:0]          log_index,
    input  logic [lpir_pkg::LOC_W-1:0]          segment_in,
    input  logic [lpir_pkg::LOC_W-1:0]          block_offset_in,
    input  logic [lpir_pkg::LOC_W-1:0]          entry_offset_in,
    output logic [lpir_pkg::STAT_W-1:0]         status,
    output logic [lpir_pkg::LOC_W-1:0]          segment_out,
    output logic [lpir_pkg::LOC_W-1:0]          block_out,
    output logic [lpir_pkg::LOC_W-1:0]          entry_out,
    output logic [lpir_pkg::IDX_W-1:0]          first_held,
    output logic [lpir_pkg::IDX_W-1:0]          last_held,
    output logic [lpir_pkg::COUNT_W-1:0]        held_count,
    output logic                                is_empty
);
    import lpir_pkg::*;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] a,
                                                    input logic [SLOT_W-1:0] b);
        logic [SLOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (SLOT_W+1)'(DEPTH))
        begin
            s = s - (SLOT_W+1)'(DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

    // ring state
    logic [SLOT_W-1:0] head_reg;
    logic [SLOT_W-1:0] head_next;
    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    logic [IDX_W-1:0]  base_reg;
    logic [IDX_W-1:0]  base_next;

    // latched item
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    loc_t              wloc_reg;

    // calc stage
    logic [IDX_W-1:0]  off_reg;
    logic [IDX_W-1:0]  last_reg;
    logic              below_reg;
    logic [IDX_W:0]    diff;
    logic [IDX_W-1:0]  held_ext;
    logic [IDX_W-1:0]  last_calc;

    // compare stage
    logic              off_ge_reg;
    logic              off_eq_reg;
    logic              off_zero_reg;
    logic              off_lt_hm1_reg;
    logic              gt_last_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] addend;

    // exec stage
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              rd_all_reg;
    logic              rd_all_next;
    logic              rd_seg_reg;
    logic              rd_seg_next;
    logic              wr_en;
    logic              empty;
    logic              full;

    // memory
    loc_t              loc_mem [DEPTH];
    loc_t              rdata_reg;

    // result
    logic [STAT_W-1:0]  res_status_reg;
    logic [LOC_W-1:0]   res_seg_reg;
    logic [LOC_W-1:0]   res_blk_reg;
    logic [LOC_W-1:0]   res_ent_reg;
    logic [IDX_W-1:0]   res_first_reg;
    logic [IDX_W-1:0]   res_last_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic               res_empty_reg;

    assign held_ext  = {{(IDX_W-CNT_W){1'b0}}, held_reg};
    assign diff      = {1'b0, idx_reg} - {1'b0, base_reg};
    assign last_calc = base_reg + held_ext - IDX_W'(1);
    assign empty     = (held_reg == '0);
    assign full      = (held_reg == CNT_W'(DEPTH));

    always_comb
    begin
        case (op_reg)
            OP_APPEND:  addend = held_reg[SLOT_W-1:0];
            OP_MIN_SEG: addend = below_reg ? '0 : off_reg[SLOT_W-1:0];
            default:    addend = off_reg[SLOT_W-1:0];
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        held_next   = held_reg;
        base_next   = base_reg;
        status_next = ST_OK;
        rd_all_next = 1'b0;
        rd_seg_next = 1'b0;
        wr_en       = 1'b0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_APPEND:
                begin
                    if (!empty && !off_eq_reg)
                    begin
                        status_next = ST_NONSEQ;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        held_next = held_reg + CNT_W'(1);
                        if (empty)
                        begin
                            base_next = idx_reg;
                        end
                    end
                end
                OP_LOOKUP:
                begin
                    if (empty || below_reg || off_ge_reg)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        rd_all_next = 1'b1;
                    end
                end
                OP_TRUNC_AFTER:
                begin
                    if (!empty)
                    begin
                        if (below_reg)
                        begin
                            held_next = '0;
                            base_next = '0;
                            head_next = '0;
                        end
                        else if (off_lt_hm1_reg)
                        begin
                            held_next = off_reg[CNT_W-1:0] + CNT_W'(1);
                        end
                    end
                end
                OP_TRUNC_BEFORE:
                begin
                    if (!empty && !below_reg && !off_zero_reg)
                    begin
                        if (gt_last_reg)
                        begin
                            held_next = '0;
                            base_next = '0;
                            head_next = '0;
                        end
                        else
                        begin
                            head_next = slot_reg;
                            held_next = held_reg - off_reg[CNT_W-1:0];
                            base_next = idx_reg;
                        end
                    end
                end
                OP_MIN_SEG:
                begin
                    if (empty)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else if (below_reg || off_zero_reg)
                    begin
                        rd_seg_next = 1'b1;
                    end
                    else if (gt_last_reg)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        rd_seg_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    held_next = '0;
                    base_next = '0;
                    head_next = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            held_reg <= '0;
            base_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            held_reg <= held_next;
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= operation;
            idx_reg      <= log_index;
            wloc_reg.seg <= segment_in;
            wloc_reg.blk <= block_offset_in;
            wloc_reg.ent <= entry_offset_in;
        end
        if (cmd.calc)
        begin
            off_reg   <= diff[IDX_W-1:0];
            below_reg <= diff[IDX_W];
            last_reg  <= last_calc;
        end
        if (cmd.cmp)
        begin
            off_ge_reg     <= (off_reg >= held_ext);
            off_eq_reg     <= (off_reg == held_ext);
            off_zero_reg   <= (off_reg == '0);
            off_lt_hm1_reg <= (off_reg < (held_ext - IDX_W'(1)));
            gt_last_reg    <= (idx_reg > last_reg);
            slot_reg       <= wrap_slot(head_reg, addend);
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            rd_all_reg <= rd_all_next;
            rd_seg_reg <= rd_seg_next;
        end
        if (cmd.finish)
        begin
            res_status_reg <= status_reg;
            res_seg_reg    <= (rd_all_reg || rd_seg_reg) ? rdata_reg.seg : '0;
            res_blk_reg    <= rd_all_reg ? rdata_reg.blk : '0;
            res_ent_reg    <= rd_all_reg ? rdata_reg.ent : '0;
            res_first_reg  <= empty ? '0 : base_reg;
            res_last_reg   <= empty ? '0 : last_calc;
            res_count_reg  <= COUNT_W'(held_reg);
            res_empty_reg  <= empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            loc_mem[slot_reg] <= wloc_reg;
        end
        rdata_reg <= loc_mem[slot_reg];
    end

    assign status      = res_status_reg;
    assign segment_out = res_seg_reg;
    assign block_out   = res_blk_reg;
    assign entry_out   = res_ent_reg;
    assign first_held  = res_first_reg;
    assign last_held   = res_last_reg;
    assign held_count  = res_count_reg;
    assign is_empty    = res_empty_reg;

endmodule

### design/log_position_index_ring.sv
// top level of the log position index ring
//
// Holds a dense ring of log entry locations keyed by consecutive log indices.
// An item (operation, log_index and the three location fields) is accepted
// at a rising edge where start is high and busy is low. busy stays high while
// the item moves through the controller: calc, compare, execute and finish.
// The result (status, location fields, first_held, last_held, held_count,
// is_empty) is shown for one cycle with done high, once the item has left the
// finish state; done comes up in the same cycle that busy drops, so a new item
// can be started then. No new item is accepted while busy is high; each item
// passes two stages of 64-bit index arithmetic and a registered memory read.
// The receiver cannot stall: a result is taken in its done cycle.
// Reset clears the ring pointers (empty ring, base index zero); the location
// memory is not cleared, only written slots are ever read back.
module log_position_index_ring (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic [lpir_pkg::OP_W-1:0]    operation,
    input  logic [lpir_pkg::IDX_W-1:0]   log_index,
    input  logic [lpir_pkg::LOC_W-1:0]   segment_in,
    input  logic [lpir_pkg::LOC_W-1:0]   block_offset_in,
    input  logic [lpir_pkg::LOC_W-1:0]   entry_offset_in,
    output logic [lpir_pkg::STAT_W-1:0]  status,
    output logic [lpir_pkg::LOC_W-1:0]   segment_out,
    output logic [lpir_pkg::LOC_W-1:0]   block_out,
    output logic [lpir_pkg::LOC_W-1:0]   entry_out,
    output logic [lpir_pkg::IDX_W-1:0]   first_held,
    output logic [lpir_pkg::IDX_W-1:0]   last_held,
    output logic [lpir_pkg::COUNT_W-1:0] held_count,
    output logic                         is_empty
);
    import lpir_pkg::*;

    ctrl_cmd_t cmd;

    lpir_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lpir_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .log_index       (log_index),
        .segment_in      (segment_in),
        .block_offset_in (block_offset_in),
        .entry_offset_in (entry_offset_in),
        .status          (status),
        .segment_out     (segment_out),
        .block_out       (block_out),
        .entry_out       (entry_out),
        .first_held      (first_held),
        .last_held       (last_held),
        .held_count      (held_count),
        .is_empty        (is_empty)
    );

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("item accepted without result five cycles later");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (held_count == '0)))
        else $error("empty flag disagrees with held count");

    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (first_held == '0 && last_held == '0))
        else $error("empty ring reports a nonzero range");

endmodule
